/* hw/rtl/e2q_pkg.sv */
`default_nettype none

package e2q_pkg;

    localparam int QUAT_WIDTH  = 16;
    localparam int ANGLE_WIDTH = 17;
    localparam int TAG_WIDTH   = 10;

    // Pipeline depth from angle input to the last quaternion stage.
    localparam int NUM_STAGES = 21;

    // Half-angle phase in turns: |a| * 2^32 / 92160, rounded. With 92160 = 2^11 * 45
    // this is 46603*|a| + floor((17*|a| + 22) / 45).
    localparam logic [31:0] PHASE_MUL      = 32'd46603;
    localparam logic [20:0] PHASE_REM      = 21'd17;
    localparam logic [20:0] PHASE_BIAS     = 21'd22;
    localparam logic [42:0] RECIP45        = 43'd2982617;
    localparam int          RECIP45_SHIFT  = 27;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;

    // Each Horner divisor d is applied as floor(v * K >> S), K = ceil(2^S / d).
    localparam logic [30:0] SIN_K [SIN_STEPS] = '{
        31'd1249445032, 31'd1908874354, 31'd1636178018, 31'd1717986919, 31'd1431655766
    };
    localparam logic [5:0]  SIN_SH [SIN_STEPS] = '{6'd37, 6'd37, 6'd36, 6'd35, 6'd33};
    localparam logic [30:0] COS_K [COS_STEPS] = '{
        31'd2082408386, 31'd1527099484, 31'd1227133514, 31'd1145324613,
        31'd1431655766, 31'd1073741824
    };
    localparam logic [5:0]  COS_SH [COS_STEPS] = '{6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31};

    typedef struct packed {
        logic [30:0] t;
        logic [29:0] x;
        logic [29:0] x2;
        logic [2:0]  oct;
    } hstate_t;

    typedef struct packed {
        logic [29:0] s;
        logic [30:0] c;
        logic [2:0]  oct;
    } trig_t;

endpackage

`default_nettype wire

/* hw/rtl/e2q_angle_cell.sv */
`default_nettype none

module e2q_angle_cell
    import e2q_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [ANGLE_WIDTH-1:0] angle,
    output hstate_t                            dout
);

    logic [16:0] mag;
    logic [31:0] p1_next;
    logic [20:0] r_next;
    logic [31:0] p1_reg;
    logic [20:0] r_reg;
    logic        sign0_reg;

    logic [42:0] rp;
    logic [14:0] rq_next;
    logic [14:0] rq_reg;
    logic [31:0] p1b_reg;
    logic        sign1_reg;

    logic [31:0] sum;
    logic [31:0] phase_next;
    logic [31:0] phase_reg;

    logic [29:0] fr;
    logic [61:0] xp;
    logic [29:0] x_next;
    logic [29:0] x_reg;
    logic [2:0]  oct_reg;

    logic [59:0] x2p;
    logic [29:0] x2_next;
    logic [29:0] x2_reg;
    logic [29:0] xb_reg;
    logic [2:0]  octb_reg;

    assign mag     = angle[ANGLE_WIDTH-1] ? 17'(-angle) : 17'(angle);
    assign p1_next = {15'b0, mag} * PHASE_MUL;
    assign r_next  = 21'(mag) * PHASE_REM + PHASE_BIAS;

    assign rp      = 43'(r_reg) * RECIP45;
    assign rq_next = rp[RECIP45_SHIFT +: 15];

    assign sum        = p1b_reg + 32'(rq_reg);
    assign phase_next = sign1_reg ? (32'd0 - sum) : sum;

    // Odd octants run backward from the octant's far edge.
    assign fr     = phase_reg[29] ? (30'h2000_0000 - {1'b0, phase_reg[28:0]})
                                  : {1'b0, phase_reg[28:0]};
    assign xp     = 62'(fr) * 62'(PI_Q30);
    assign x_next = xp[60:31];

    assign x2p     = 60'(x_reg) * 60'(x_reg);
    assign x2_next = x2p[59:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= p1_next;
            r_reg     <= r_next;
            sign0_reg <= angle[ANGLE_WIDTH-1];
            rq_reg    <= rq_next;
            p1b_reg   <= p1_reg;
            sign1_reg <= sign0_reg;
            phase_reg <= phase_next;
            x_reg     <= x_next;
            oct_reg   <= phase_reg[31:29];
            x2_reg    <= x2_next;
            xb_reg    <= x_reg;
            octb_reg  <= oct_reg;
        end
    end

    assign dout = '{t: ONE_Q30, x: xb_reg, x2: x2_reg, oct: octb_reg};

endmodule

`default_nettype wire

/* hw/rtl/e2q_horner_cell.sv */
`default_nettype none

module e2q_horner_cell
    import e2q_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] recip,
    input  wire logic [5:0]  shift,
    input  wire hstate_t     din,
    output hstate_t          dout
);

    logic [60:0] prod;
    hstate_t     mid_next;
    hstate_t     mid_reg;
    logic [60:0] qfull;
    logic [60:0] qsh;
    hstate_t     out_next;
    hstate_t     out_reg;

    // First half: x2 * t in Q30; the t field carries the product to the second half.
    assign prod     = 61'(din.x2) * 61'(din.t);
    assign mid_next = '{t: prod[60:30], x: din.x, x2: din.x2, oct: din.oct};

    // Second half: divide by the step's constant and subtract from one.
    assign qfull    = 61'(mid_reg.t[29:0]) * 61'(recip);
    assign qsh      = qfull >> shift;
    assign out_next = '{t: ONE_Q30 - qsh[30:0], x: mid_reg.x, x2: mid_reg.x2,
                        oct: mid_reg.oct};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg <= mid_next;
            out_reg <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

`default_nettype wire

/* hw/rtl/e2q_quat.sv */
`default_nettype none

module e2q_quat
    import e2q_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire trig_t                        trig_x,
    input  wire trig_t                        trig_y,
    input  wire trig_t                        trig_z,
    output logic signed [QUAT_WIDTH-1:0]      w_out,
    output logic signed [QUAT_WIDTH-1:0]      x_out,
    output logic signed [QUAT_WIDTH-1:0]      y_out,
    output logic signed [QUAT_WIDTH-1:0]      z_out
);

    localparam int RSH = 61 - QUAT_WIDTH;
    localparam logic signed [62:0] QMAX = (63'sd1 <<< (QUAT_WIDTH - 1)) - 63'sd1;
    localparam logic signed [62:0] QMIN = -QMAX - 63'sd1;
    localparam logic signed [62:0] RHALF = 63'sd1 <<< (RSH - 1);

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } sc_t;

    function automatic sc_t unfold(input trig_t tr);
        logic signed [31:0] ss;
        logic signed [31:0] cc;
        sc_t                r;
        ss = signed'({2'b0, tr.s});
        cc = signed'({1'b0, tr.c});
        case (tr.oct)
            3'd0: r = '{s: ss, c: cc};
            3'd1: r = '{s: cc, c: ss};
            3'd2: r = '{s: cc, c: -ss};
            3'd3: r = '{s: ss, c: -cc};
            3'd4: r = '{s: -ss, c: -cc};
            3'd5: r = '{s: -cc, c: -ss};
            3'd6: r = '{s: -cc, c: ss};
            default: r = '{s: -ss, c: cc};
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + 64'sd536870912) >>> 30;
        return signed'(r[31:0]);
    endfunction

    function automatic logic signed [QUAT_WIDTH-1:0] finish(input logic signed [62:0] v);
        logic signed [62:0] r;
        r = (v + RHALF) >>> RSH;
        if (r > QMAX)
        begin
            r = QMAX;
        end
        if (r < QMIN)
        begin
            r = QMIN;
        end
        return signed'(r[QUAT_WIDTH-1:0]);
    endfunction

    sc_t ax_reg, ay_reg, az_reg;
    sc_t az2_reg;

    logic signed [63:0] pw, px, py, pz;
    logic signed [31:0] tw_reg, tx_reg, ty_reg, tz_reg;

    logic signed [63:0] m0, m1, m2, m3, m4, m5, m6, m7;
    logic signed [61:0] pw1_reg, pw2_reg, px1_reg, px2_reg;
    logic signed [61:0] py1_reg, py2_reg, pz1_reg, pz2_reg;

    logic signed [QUAT_WIDTH-1:0] w_reg, x_reg, y_reg, z_reg;

    // Inner product qy * qx.
    assign pw = ay_reg.c * ax_reg.c;
    assign px = ay_reg.c * ax_reg.s;
    assign py = ay_reg.s * ax_reg.c;
    assign pz = -(ay_reg.s * ax_reg.s);

    // Outer product qz * (qy * qx).
    assign m0 = az2_reg.c * tw_reg;
    assign m1 = az2_reg.s * tz_reg;
    assign m2 = az2_reg.c * tx_reg;
    assign m3 = az2_reg.s * ty_reg;
    assign m4 = az2_reg.c * ty_reg;
    assign m5 = az2_reg.s * tx_reg;
    assign m6 = az2_reg.c * tz_reg;
    assign m7 = az2_reg.s * tw_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg  <= unfold(trig_x);
            ay_reg  <= unfold(trig_y);
            az_reg  <= unfold(trig_z);

            tw_reg  <= rnd30(pw);
            tx_reg  <= rnd30(px);
            ty_reg  <= rnd30(py);
            tz_reg  <= rnd30(pz);
            az2_reg <= az_reg;

            pw1_reg <= m0[61:0];
            pw2_reg <= m1[61:0];
            px1_reg <= m2[61:0];
            px2_reg <= m3[61:0];
            py1_reg <= m4[61:0];
            py2_reg <= m5[61:0];
            pz1_reg <= m6[61:0];
            pz2_reg <= m7[61:0];

            w_reg   <= finish(63'(pw1_reg) - 63'(pw2_reg));
            x_reg   <= finish(63'(px1_reg) - 63'(px2_reg));
            y_reg   <= finish(63'(py1_reg) + 63'(py2_reg));
            z_reg   <= finish(63'(pz1_reg) + 63'(pz2_reg));
        end
    end

    assign w_out = w_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

/* hw/rtl/euler_to_quaternion_top.sv */
// Channel   Handshake             Payload
// input     in_valid / in_ready   pitch_deg, yaw_deg, roll_deg, frame_tag
// output    out_valid / out_ready quat_w, quat_x, quat_y, quat_z, frame_tag_out
//
// One transfer per clock is taken and delivered when neither side stalls.
// The path has 21 pipeline stages, in the angle cell, the Horner cell chain
// and the quaternion block, followed by one output register.
// rst_n clears only the valid bits; payload registers are not reset.
// When the output register holds an untaken result, the pipeline keeps moving
// until its last stage is full, so bubbles are filled while the output stalls.
`default_nettype none

module euler_to_quaternion_top
    import e2q_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [ANGLE_WIDTH-1:0] pitch_deg,
    input  wire logic signed [ANGLE_WIDTH-1:0] yaw_deg,
    input  wire logic signed [ANGLE_WIDTH-1:0] roll_deg,
    input  wire logic        [TAG_WIDTH-1:0]   frame_tag,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [QUAT_WIDTH-1:0]       quat_w,
    output logic signed [QUAT_WIDTH-1:0]       quat_x,
    output logic signed [QUAT_WIDTH-1:0]       quat_y,
    output logic signed [QUAT_WIDTH-1:0]       quat_z,
    output logic        [TAG_WIDTH-1:0]        frame_tag_out
);

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    logic                  adv;
    logic                  out_load;
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  out_valid_reg;

    logic [TAG_WIDTH-1:0]  tag_reg [NUM_STAGES];

    logic signed [ANGLE_WIDTH-1:0] angle_in [3];
    hstate_t sin_link [3][SIN_STEPS+1];
    hstate_t cos_link [3][COS_STEPS+1];

    logic [60:0] sprod [3];
    logic [29:0] s1_reg [3];
    logic [2:0]  oct1_reg [3];
    logic [29:0] s2_reg [3];
    logic [2:0]  oct2_reg [3];
    trig_t       trig_q [3];

    logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;
    logic signed [QUAT_WIDTH-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic [TAG_WIDTH-1:0]         tag_out_reg;

    // The output register can take a result when empty or being drained.
    assign out_load = !out_valid_reg || out_ready;
    assign adv      = !vld_reg[NUM_STAGES-1] || out_load;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[NUM_STAGES-2:0], in_valid};
            end
            if (out_load)
            begin
                out_valid_reg <= vld_reg[NUM_STAGES-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= frame_tag;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign angle_in[AXIS_X] = pitch_deg;
    assign angle_in[AXIS_Y] = yaw_deg;
    assign angle_in[AXIS_Z] = roll_deg;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        e2q_angle_cell u_angle (
            .clk   (clk),
            .en    (adv),
            .angle (angle_in[a]),
            .dout  (sin_link[a][0])
        );

        assign cos_link[a][0] = sin_link[a][0];

        for (genvar k = 0; k < SIN_STEPS; k++)
        begin : g_sin
            e2q_horner_cell u_cell (
                .clk   (clk),
                .en    (adv),
                .recip (SIN_K[k]),
                .shift (SIN_SH[k]),
                .din   (sin_link[a][k]),
                .dout  (sin_link[a][k+1])
            );
        end

        for (genvar k = 0; k < COS_STEPS; k++)
        begin : g_cos
            e2q_horner_cell u_cell (
                .clk   (clk),
                .en    (adv),
                .recip (COS_K[k]),
                .shift (COS_SH[k]),
                .din   (cos_link[a][k]),
                .dout  (cos_link[a][k+1])
            );
        end

        // The sine series ends one step early; its final multiply and one delay
        // stage line it up with the cosine series.
        assign sprod[a] = 61'(sin_link[a][SIN_STEPS].x) * 61'(sin_link[a][SIN_STEPS].t);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s1_reg[a]   <= sprod[a][59:30];
                oct1_reg[a] <= sin_link[a][SIN_STEPS].oct;
                s2_reg[a]   <= s1_reg[a];
                oct2_reg[a] <= oct1_reg[a];
            end
        end

        assign trig_q[a] = '{s: s2_reg[a], c: cos_link[a][COS_STEPS].t, oct: oct2_reg[a]};
    end

    e2q_quat u_quat (
        .clk    (clk),
        .en     (adv),
        .trig_x (trig_q[AXIS_X]),
        .trig_y (trig_q[AXIS_Y]),
        .trig_z (trig_q[AXIS_Z]),
        .w_out  (qw),
        .x_out  (qx),
        .y_out  (qy),
        .z_out  (qz)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            qw_reg      <= qw;
            qx_reg      <= qx;
            qy_reg      <= qy;
            qz_reg      <= qz;
            tag_out_reg <= tag_reg[NUM_STAGES-1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign quat_w        = qw_reg;
    assign quat_x        = qx_reg;
    assign quat_y        = qy_reg;
    assign quat_z        = qz_reg;
    assign frame_tag_out = tag_out_reg;

endmodule

`default_nettype wire
